### rtl/core/cisv_pkg.sv
// shared types, codes and sizes for the cbor item skip validator
// no dependencies; imported by every module under rtl/core
package cisv_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int COUNT_W     = 64;
  localparam int LEN_W       = 32;
  localparam int LIMIT_W     = 4;
  localparam int CMP_W       = (LEVEL_W > LIMIT_W) ? LEVEL_W : LIMIT_W;

  localparam logic [LIMIT_W-1:0] DEPTH_LIMIT_RST = 4'd8;

  // major types
  localparam logic [2:0] MAJ_BSTR   = 3'd2;
  localparam logic [2:0] MAJ_TSTR   = 3'd3;
  localparam logic [2:0] MAJ_ARRAY  = 3'd4;
  localparam logic [2:0] MAJ_MAP    = 3'd5;
  localparam logic [2:0] MAJ_TAG    = 3'd6;
  localparam logic [2:0] MAJ_SIMPLE = 3'd7;

  // additional info codes
  localparam logic [4:0] AI_ARG1      = 5'd24;
  localparam logic [4:0] AI_ARG8      = 5'd27;
  localparam logic [4:0] AI_SIMPLE_LO = 5'd20;
  localparam logic [4:0] AI_SIMPLE_HI = 5'd23;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_DONE       = 2'd1,
    ST_ERROR      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MAJOR    = 3'd1,
    ERR_RESERVED = 3'd2,
    ERR_DEEP     = 3'd3,
    ERR_TRUNC    = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    PH_HEAD    = 3'b001,
    PH_ARG     = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  // core to stack
  typedef struct packed {
    logic               clear;
    logic               pop;
    logic               push;
    logic               push_map;
    logic [COUNT_W-1:0] push_count;
  } stack_cmd_t;

  // stack to core
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               top_done;
  } stack_stat_t;

endpackage

### rtl/core/cisv_stack.sv
// nesting stack with a combinational pop cascade over all entries
// depends on cisv_pkg
module cisv_stack import cisv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        commit,
  input  stack_cmd_t  cmd,
  output stack_stat_t stat
);

  logic [LEVEL_W-1:0] level;
  logic [COUNT_W-1:0] count [STACK_DEPTH];
  logic               due   [STACK_DEPTH];
  logic               is_map[STACK_DEPTH];

  logic [STACK_DEPTH-1:0] stop;
  logic [IDX_W-1:0]       sel;
  logic                   found;
  logic                   sel_toggle;

  // an entry stops the cascade if it only flips to its value half or keeps elements
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stop[i] = (is_map[i] && !due[i]) || (count[i] != COUNT_W'(1));
    end
  end

  // deepest live entry that stops the cascade
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if ((LEVEL_W'(i) < level) && stop[i]) begin
        found = 1'b1;
        sel   = IDX_W'(i);
      end
    end
  end

  assign sel_toggle    = is_map[sel] && !due[sel];
  assign stat.level    = level;
  assign stat.top_done = !found;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (commit) begin
      if (cmd.clear) begin
        level <= '0;
      end else if (cmd.push) begin
        level <= level + LEVEL_W'(1);
      end else if (cmd.pop) begin
        level <= found ? (LEVEL_W'(sel) + LEVEL_W'(1)) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit && cmd.push) begin
      count[level[IDX_W-1:0]]  <= cmd.push_count;
      due[level[IDX_W-1:0]]    <= 1'b0;
      is_map[level[IDX_W-1:0]] <= cmd.push_map;
    end else if (commit && cmd.pop && found) begin
      if (sel_toggle) begin
        due[sel] <= 1'b1;
      end else begin
        due[sel]   <= 1'b0;
        count[sel] <= count[sel] - COUNT_W'(1);
      end
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_W'(STACK_DEPTH))
    else $error("nesting level past stack depth");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    commit |-> !(cmd.push && cmd.pop))
    else $error("push and pop in the same request");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (commit && cmd.push && !cmd.clear) |=> level == $past(level) + LEVEL_W'(1))
    else $error("push did not raise the level");

endmodule

### rtl/core/cisv_core.sv
// head decoder, argument and payload tracking, per-byte status
// depends on cisv_pkg; drives cisv_stack through stack_cmd_t
module cisv_core import cisv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               commit,
  input  logic [7:0]         data_byte,
  input  logic               end_of_buffer,
  input  logic [LIMIT_W-1:0] depth_limit,
  input  stack_stat_t        stat,
  output stack_cmd_t         cmd,
  output status_t            status,
  output err_t               error_kind,
  output logic [LEN_W-1:0]   item_length
);

  phase_t             phase, phase_next;
  logic [2:0]         head_major, head_major_next;
  logic [3:0]         arg_left, arg_left_next;
  logic [63:0]        arg_value, arg_value_next;
  logic [COUNT_W-1:0] payload_left, payload_left_next;
  logic [LEN_W-1:0]   byte_count, byte_count_next;

  logic [2:0]         major_b;
  logic [4:0]         ai;
  logic [63:0]        av;
  logic [3:0]         left_dec;
  logic [COUNT_W-1:0] pl_dec;
  logic               hd_req;
  logic [63:0]        hd_v;
  logic [2:0]         hd_major;
  logic               elem_req;
  logic               done;
  logic               deep;
  logic               final_byte;
  err_t               err;

  assign major_b = data_byte[7:5];
  assign ai      = data_byte[4:0];
  assign av      = {arg_value[55:0], data_byte};
  assign left_dec = (arg_left != 4'd0) ? (arg_left - 4'd1) : 4'd0;
  assign pl_dec   = (payload_left != '0) ? (payload_left - COUNT_W'(1)) : '0;

  // level limit is the smaller of the register and the stack size
  assign deep = (CMP_W'(stat.level) >= CMP_W'(depth_limit)) ||
                (CMP_W'(stat.level) >= CMP_W'(STACK_DEPTH));

  always_comb begin
    phase_next        = phase;
    head_major_next   = head_major;
    arg_left_next     = arg_left;
    arg_value_next    = arg_value;
    payload_left_next = payload_left;
    byte_count_next   = (byte_count != '1) ? (byte_count + LEN_W'(1)) : byte_count;
    cmd               = '0;
    err               = ERR_NONE;
    hd_req            = 1'b0;
    hd_v              = '0;
    hd_major          = head_major;
    elem_req          = 1'b0;
    done              = 1'b0;

    case (phase)
      PH_HEAD: begin
        head_major_next = major_b;
        hd_major        = major_b;
        if (major_b == MAJ_TAG) begin
          err = ERR_MAJOR;
        end else if (major_b == MAJ_SIMPLE) begin
          if (ai >= AI_SIMPLE_LO && ai <= AI_SIMPLE_HI) begin
            elem_req = 1'b1;
          end else begin
            err = ERR_MAJOR;
          end
        end else if (ai < AI_ARG1) begin
          hd_req = 1'b1;
          hd_v   = 64'(ai);
        end else if (ai <= AI_ARG8) begin
          // 1, 2, 4 or 8 argument bytes
          arg_left_next  = 4'd1 << ai[1:0];
          arg_value_next = '0;
          phase_next     = PH_ARG;
        end else begin
          err = ERR_RESERVED;
        end
      end
      PH_ARG: begin
        arg_value_next = av;
        arg_left_next  = left_dec;
        if (left_dec == 4'd0) begin
          hd_req = 1'b1;
          hd_v   = av;
        end
      end
      PH_PAYLOAD: begin
        payload_left_next = pl_dec;
        if (pl_dec == '0) begin
          elem_req = 1'b1;
        end
      end
      default: begin
        phase_next = PH_HEAD;
      end
    endcase

    // head complete with argument hd_v
    if (hd_req) begin
      case (hd_major)
        MAJ_BSTR, MAJ_TSTR: begin
          if (hd_v != '0) begin
            payload_left_next = hd_v;
            phase_next        = PH_PAYLOAD;
          end else begin
            elem_req = 1'b1;
          end
        end
        MAJ_ARRAY, MAJ_MAP: begin
          if (hd_v != '0) begin
            if (deep) begin
              err = ERR_DEEP;
            end else begin
              cmd.push       = 1'b1;
              cmd.push_map   = (hd_major == MAJ_MAP);
              cmd.push_count = hd_v;
              phase_next     = PH_HEAD;
            end
          end else begin
            elem_req = 1'b1;
          end
        end
        default: begin
          elem_req = 1'b1;
        end
      endcase
    end

    if (elem_req) begin
      phase_next = PH_HEAD;
      cmd.pop    = 1'b1;
      done       = stat.top_done;
    end

    if (err == ERR_NONE && !done && end_of_buffer) begin
      err = ERR_TRUNC;
    end

    final_byte = (err != ERR_NONE) || done;
    cmd.clear  = final_byte;
    if (final_byte) begin
      phase_next        = PH_HEAD;
      head_major_next   = '0;
      arg_left_next     = '0;
      arg_value_next    = '0;
      payload_left_next = '0;
      byte_count_next   = '0;
    end
  end

  assign status      = (err != ERR_NONE) ? ST_ERROR : (done ? ST_DONE : ST_INCOMPLETE);
  assign error_kind  = err;
  assign item_length = (byte_count != '1) ? (byte_count + LEN_W'(1)) : byte_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEAD;
      head_major   <= '0;
      arg_left     <= '0;
      arg_value    <= '0;
      payload_left <= '0;
      byte_count   <= '0;
    end else if (commit) begin
      phase        <= phase_next;
      head_major   <= head_major_next;
      arg_left     <= arg_left_next;
      arg_value    <= arg_value_next;
      payload_left <= payload_left_next;
      byte_count   <= byte_count_next;
    end
  end

endmodule

### rtl/core/cbor_item_skip_validator.sv
// top level of the cbor item skip validator: input register, core, result register
// depends on cisv_pkg, cisv_stack and cisv_core
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tdata[7:0] data_byte, tlast end_of_buffer
//  m_axis   | out       | m_axis_tvalid/tready    | tdata[31:0] item_length,
//           |           |                         | tuser[1:0] status, tuser[4:2] error_kind
//  cfg      | in        | cfg_valid/cfg_ready     | cfg_data[3:0] depth_limit
//
// one byte per cycle sustained while m_axis accepts; results go out from the result register
// the byte is evaluated combinationally between the input register and the result register,
// including the stack pop cascade, so state is ready for the next byte right away
// rst clears all control state and sets depth_limit to 8; stack entries keep no reset
// when m_axis stalls, the input register holds one byte and s_axis_tready drops
// cfg_ready is always high; a write takes effect on the next byte evaluated
module cbor_item_skip_validator import cisv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [LEN_W-1:0]   m_axis_tdata,   // [31:0] item_length
  output logic [4:0]         m_axis_tuser,   // [1:0] status, [4:2] error_kind
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data        // [3:0] depth_limit
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // result register
  logic             out_valid;
  status_t          out_status;
  err_t             out_err;
  logic [LEN_W-1:0] out_len;

  logic [LIMIT_W-1:0] depth_limit;

  logic             fire;
  stack_cmd_t       cmd;
  stack_stat_t      stat;
  status_t          c_status;
  err_t             c_err;
  logic [LEN_W-1:0] c_len;

  // evaluate a byte when the result register is free or being drained
  assign fire          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= DEPTH_LIMIT_RST;
    end else if (cfg_valid) begin
      depth_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  cisv_core u_core (
    .clk           (clk),
    .rst           (rst),
    .commit        (fire),
    .data_byte     (in_byte),
    .end_of_buffer (in_last),
    .depth_limit   (depth_limit),
    .stat          (stat),
    .cmd           (cmd),
    .status        (c_status),
    .error_kind    (c_err),
    .item_length   (c_len)
  );

  cisv_stack u_stack (
    .clk    (clk),
    .rst    (rst),
    .commit (fire),
    .cmd    (cmd),
    .stat   (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= c_status;
      out_err    <= c_err;
      out_len    <= c_len;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_len;
  assign m_axis_tuser  = {out_err, out_status};

  // error code present exactly on error results
  a_err_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_status == ST_ERROR) == (out_err != ERR_NONE)))
    else $error("status and error kind disagree");

  // an item's first byte reports length one
  a_len_restart: assert property (@(posedge clk) disable iff (rst)
    (fire && c_status != ST_INCOMPLETE) ##1 fire |-> c_len == LEN_W'(1))
    else $error("length not restarted after item end");

  // a held input byte is not lost while the result side stalls
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !fire) |=> (in_valid && $stable(in_byte) && $stable(in_last)))
    else $error("stalled input byte overwritten");

endmodule

### tb/sv/cbor_item_skip_validator_test.sv
// self-checking testbench for cbor_item_skip_validator: directed heads, then random
// well-formed, truncated and corrupted cbor items under several depth limits
// depends on cisv_pkg and the cbor_item_skip_validator rtl
module cbor_item_skip_validator_test import cisv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // major types without a package name
  localparam logic [2:0] MAJ_UINT = 3'd0;
  localparam logic [2:0] MAJ_NINT = 3'd1;

  localparam int unsigned BYTES_PER_PHASE = 150;
  localparam int unsigned HOLD_OFF_AFTER  = 300;   // results seen before the long stall
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned DRAIN_MARGIN    = 4;     // result lands after the input and result registers
  localparam int unsigned WATCHDOG_LIMIT  = 2000;  // cycles with no request moving

  // depth limits in run order; the first phase runs on the reset value
  localparam int unsigned NUM_PHASES = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_PLAN [NUM_PHASES] =
    '{DEPTH_LIMIT_RST, 4'd0, 4'd8, 4'd3, 4'd1, 4'd7, 4'd5};

  // opening bytes as {end_of_buffer, data_byte}
  localparam int unsigned NUM_OPENING = 23;
  localparam logic [8:0] OPENING_BYTES [NUM_OPENING] = '{
    9'h000,                  // smallest unsigned
    9'h017,                  // largest immediate argument
    9'h018, 9'h0ff,          // one argument byte, all ones
    9'h020,                  // negative integer
    9'h0c0,                  // tag major is rejected
    9'h0f4, 9'h0f7,          // simple values at both ends of the accepted range
    9'h0f3,                  // simple value just below the range
    9'h0ff,                  // break code on major 7
    9'h01c,                  // reserved additional info
    9'h05f,                  // indefinite length byte string
    9'h040, 9'h060,          // empty strings complete at the head
    9'h080, 9'h0a0,          // empty containers complete at the head
    9'h0a1, 9'h001, 9'h061, 9'h041,  // map of one pair, value is a one-byte text string
    9'h082, 9'h100,          // array cut short by end of buffer
    9'h1c1                   // bad major on the final byte beats truncation
  };

  // ---------------------------------------------------------------------------
  // scoreboard: tracks the parse state of the stream and predicts one verdict per byte
  // ---------------------------------------------------------------------------
  class item_check_scoreboard;
    typedef struct packed {
      status_t          st;
      err_t             ek;
      logic [LEN_W-1:0] len;
    } verdict_t;

    logic [LIMIT_W-1:0] depth_limit = DEPTH_LIMIT_RST;
    phase_t             parse_phase;
    logic [2:0]         head_major;
    logic [3:0]         arg_left;
    logic [63:0]        arg_value;
    logic [63:0]        payload_left;
    int unsigned        level;
    logic [63:0]        pending[STACK_DEPTH];
    bit                 value_due[STACK_DEPTH];
    bit                 is_map[STACK_DEPTH];
    logic [LEN_W-1:0]   byte_count;
    verdict_t           expected_verdicts[$];
    int unsigned        checked;
    int unsigned        mismatches;

    function new();
      restart();
    endfunction

    function void restart();
      parse_phase  = PH_HEAD;
      head_major   = '0;
      arg_left     = '0;
      arg_value    = '0;
      payload_left = '0;
      level        = 0;
      byte_count   = '0;
      foreach (pending[i]) begin
        pending[i]   = '0;
        value_due[i] = 1'b0;
        is_map[i]    = 1'b0;
      end
    endfunction

    function int unsigned outstanding();
      return expected_verdicts.size();
    endfunction

    // one element finished; walk up the stack, returns 1 when the top item is done
    function bit element_done();
      bit settled;
      bit top;
      int unsigned idx;
      settled     = 1'b0;
      top         = 1'b0;
      parse_phase = PH_HEAD;
      while (!settled) begin
        if (level == 0 || level > STACK_DEPTH) begin
          top     = 1'b1;
          settled = 1'b1;
        end else begin
          idx = level - 1;
          if (is_map[idx] && !value_due[idx]) begin
            // key done, value still due
            value_due[idx] = 1'b1;
            settled        = 1'b1;
          end else begin
            value_due[idx] = 1'b0;
            pending[idx]   = pending[idx] - 64'd1;
            if (pending[idx] != 0)
              settled = 1'b1;
            else
              level = idx;
          end
        end
      end
      return top;
    endfunction

    // head decoded with argument v
    function err_t head_done(logic [63:0] v, output bit top_done);
      int unsigned lim;
      lim      = (depth_limit < STACK_DEPTH) ? depth_limit : STACK_DEPTH;
      top_done = 1'b0;
      if ((head_major == MAJ_BSTR || head_major == MAJ_TSTR) && v != 0) begin
        payload_left = v;
        parse_phase  = PH_PAYLOAD;
        return ERR_NONE;
      end
      if ((head_major == MAJ_ARRAY || head_major == MAJ_MAP) && v != 0) begin
        if (level >= lim || level >= STACK_DEPTH)
          return ERR_DEEP;
        pending[level]   = v;
        value_due[level] = 1'b0;
        is_map[level]    = (head_major == MAJ_MAP);
        level++;
        parse_phase = PH_HEAD;
        return ERR_NONE;
      end
      top_done = element_done();
      return ERR_NONE;
    endfunction

    // accepted input byte: work out its verdict and queue it
    function void predict_byte(logic [7:0] b, logic last);
      err_t     ek;
      bit       done;
      verdict_t v;
      ek   = ERR_NONE;
      done = 1'b0;
      if (byte_count != '1)
        byte_count++;
      case (parse_phase)
        PH_HEAD: begin
          head_major = b[7:5];
          if (head_major == MAJ_TAG) begin
            ek = ERR_MAJOR;
          end else if (head_major == MAJ_SIMPLE) begin
            if (b[4:0] >= AI_SIMPLE_LO && b[4:0] <= AI_SIMPLE_HI)
              done = element_done();
            else
              ek = ERR_MAJOR;
          end else if (b[4:0] < AI_ARG1) begin
            ek = head_done(64'(b[4:0]), done);
          end else if (b[4:0] <= AI_ARG8) begin
            arg_left    = 4'd1 << (b[4:0] - AI_ARG1);
            arg_value   = '0;
            parse_phase = PH_ARG;
          end else begin
            ek = ERR_RESERVED;
          end
        end
        PH_ARG: begin
          arg_value = {arg_value[55:0], b};
          if (arg_left > 0)
            arg_left--;
          if (arg_left == 0)
            ek = head_done(arg_value, done);
        end
        default: begin
          if (payload_left > 0)
            payload_left--;
          if (payload_left == 0)
            done = element_done();
        end
      endcase
      if (ek == ERR_NONE && !done && last)
        ek = ERR_TRUNC;
      v.st  = (ek != ERR_NONE) ? ST_ERROR : (done ? ST_DONE : ST_INCOMPLETE);
      v.ek  = ek;
      v.len = byte_count;
      expected_verdicts.push_back(v);
      if (ek != ERR_NONE || done)
        restart();
    endfunction

    function void report_mismatch(string what);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch on result %0d: %s", $realtime, checked, what);
    endfunction

    // accepted result: compare with the oldest verdict
    function void check_result(logic [1:0] st, logic [2:0] ek, logic [LEN_W-1:0] len);
      verdict_t exp;
      checked++;
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("nothing expected, got status %0d kind %0d length %0d",
                                  st, ek, len));
        return;
      end
      exp = expected_verdicts.pop_front();
      if (st !== exp.st || ek !== exp.ek || len !== exp.len)
        report_mismatch($sformatf(
          "status %0d/%0d kind %0d/%0d length %0d/%0d (expected/actual)",
          exp.st, st, exp.ek, ek, exp.len, len));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and block
  // ---------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;   // [7:0] data_byte
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [LEN_W-1:0] m_axis_tdata;        // [31:0] item_length
  logic [4:0]       m_axis_tuser;        // [1:0] status, [4:2] error_kind
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;     // [3:0] depth_limit

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cbor_item_skip_validator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  item_check_scoreboard sb = new();

  logic [8:0]  frame_q[$];      // bytes of the next frame as {end_of_buffer, data_byte}
  int unsigned bytes_sent;
  bit          calm;            // set for stretches with no idling on either side
  bit          held_off;
  int unsigned idle_cycles;

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // head with argument val; short values sometimes go out non-minimal
  function automatic void put_head(logic [2:0] maj, logic [63:0] val);
    int unsigned w;
    if (val < 24 && $urandom_range(0, 3) != 0) begin
      frame_q.push_back({1'b0, maj, val[4:0]});
      return;
    end
    w = (val < 64'h100) ? 0 : (val < 64'h1_0000) ? 1 : (val < 64'h1_0000_0000) ? 2 : 3;
    if ($urandom_range(0, 3) == 0)
      w = $urandom_range(w, 3);
    frame_q.push_back({1'b0, maj, 5'(AI_ARG1 + w)});
    // argument goes out big-endian
    for (int i = (1 << w) - 1; i >= 0; i--)
      frame_q.push_back({1'b0, val[8*i +: 8]});
  endfunction

  // one well-formed item; deep items favor containers to cross the depth limit
  function automatic void build_item(bit deep);
    int unsigned left[10];   // elements still owed by each open container
    int unsigned d;
    int unsigned budget;
    int unsigned max_depth;
    int unsigned n;
    bit          leaf;
    d         = 0;
    budget    = deep ? 16 : $urandom_range(1, 10);
    max_depth = deep ? 9 : $urandom_range(0, 4);
    do begin
      leaf = 1'b1;
      if (d < max_depth && budget > 0 &&
          (deep ? $urandom_range(0, 7) != 0 : $urandom_range(0, 2) == 0)) begin
        n = $urandom_range(1, 3);
        if ($urandom_range(0, 1) == 1) begin
          put_head(MAJ_MAP, 64'(n));
          left[d] = 2 * n;   // key and value each count
        end else begin
          put_head(MAJ_ARRAY, 64'(n));
          left[d] = n;
        end
        d++;
        leaf = 1'b0;
      end else begin
        case ($urandom_range(0, 6))
          0, 1: put_head(3'($urandom_range(MAJ_UINT, MAJ_NINT)),
                         {$urandom, $urandom} >> $urandom_range(0, 63));
          2, 3: begin
            n = $urandom_range(0, 5);
            put_head(3'($urandom_range(MAJ_BSTR, MAJ_TSTR)), 64'(n));
            repeat (n) frame_q.push_back({1'b0, 8'($urandom)});
          end
          4: frame_q.push_back({1'b0, MAJ_SIMPLE,
                                5'($urandom_range(AI_SIMPLE_LO, AI_SIMPLE_HI))});
          default: put_head(3'($urandom_range(MAJ_ARRAY, MAJ_MAP)), 64'd0);  // empty
        endcase
      end
      if (budget > 0)
        budget--;
      if (leaf) begin
        // close every container whose last element this was
        while (d > 0 && left[d-1] == 1)
          d--;
        if (d > 0)
          left[d-1]--;
      end
    end while (d > 0);
  endfunction

  // offer each byte of frame_q until its request is taken
  task automatic send_frame();
    int unsigned gap;
    foreach (frame_q[i]) begin
      gap = pick_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= frame_q[i][7:0];
      s_axis_tlast  <= frame_q[i][8];
      do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
      @(negedge clk);
      bytes_sent++;
    end
  endtask

  // stop offering and wait for every outstanding verdict
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0)
      @(negedge clk);
    repeat (DRAIN_MARGIN) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // monitor and watchdog: both channels sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        sb.predict_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser[1:0], m_axis_tuser[4:2], m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random back-pressure plus one long hold-off that fills the block
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    @(negedge clk);
    while (rst)
      @(negedge clk);
    forever begin
      if (!held_off && sb.checked >= HOLD_OFF_AFTER) begin
        // input keeps coming while results are refused, so s_axis_tready must drop
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase_end;
    int unsigned mode;
    int unsigned cut;
    logic [63:0] big;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed heads under the reset depth limit
    foreach (OPENING_BYTES[i])
      frame_q.push_back(OPENING_BYTES[i]);
    send_frame();

    for (int k = 0; k < NUM_PHASES; k++) begin
      if (k != 0) begin
        // new depth limit only with the block empty
        drain_results();
        cfg_data  <= LIMIT_PLAN[k];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        sb.depth_limit = LIMIT_PLAN[k];
        @(negedge clk);
        cfg_valid <= 1'b0;
      end
      phase_end = bytes_sent + BYTES_PER_PHASE;
      while (bytes_sent < phase_end) begin
        if ($urandom_range(0, 9) == 0)
          calm = !calm;
        frame_q.delete();
        mode = $urandom_range(0, 99);
        if (mode < 85) begin
          build_item($urandom_range(0, 4) == 0);
          cut = $urandom_range(0, frame_q.size() - 1);
          if (mode < 60) begin
            // clean item, end of buffer on its last byte half the time
            frame_q[frame_q.size()-1][8] = 1'($urandom_range(0, 1));
          end else if (mode < 75) begin
            // buffer ends inside the item
            while (frame_q.size() > cut + 1)
              void'(frame_q.pop_back());
            frame_q[cut][8] = 1'b1;
          end else begin
            // one byte overwritten with anything
            frame_q[cut][7:0] = 8'($urandom);
          end
        end else if (mode < 93) begin
          // raw noise
          repeat ($urandom_range(1, 6))
            frame_q.push_back({1'($urandom_range(0, 3) == 0), 8'($urandom)});
        end else begin
          // huge string or container length, buffer ends a few elements later
          big = {$urandom, $urandom} | 64'd1;
          if ($urandom_range(0, 3) == 0)
            big = '1;
          put_head(3'($urandom_range(MAJ_BSTR, MAJ_MAP)), big);
          repeat ($urandom_range(1, 3)) build_item(1'b0);
          frame_q[frame_q.size()-1][8] = 1'b1;
        end
        send_frame();
      end
    end

    drain_results();
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
